// ----- design/zero_suppress_calibrate_hits_unit_assert.svh -----
// ----------------------------------------------------------------------------
// zero suppress calibrate hits unit assertion macros
// concurrent checks clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ZERO_SUPPRESS_CALIBRATE_HITS_UNIT_ASSERT_SVH
`define ZERO_SUPPRESS_CALIBRATE_HITS_UNIT_ASSERT_SVH

// same-cycle implication
`define ZSCH_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ZSCH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/zsch_pkg.sv -----
// ----------------------------------------------------------------------------
// zsch_pkg
// field widths, action, layer and record codes of the hit calibration unit
// ----------------------------------------------------------------------------
package zsch_pkg;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 2;

  localparam int NUM_LAYERS = 4;
  localparam int CNT_W      = 5;
  localparam int TOT_W      = 7;

  localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;
  localparam logic [TOT_W-1:0] TOT_MAX = 7'd127;

  // input actions
  localparam logic [2:0] ACT_SAMPLE  = 3'd0;
  localparam logic [2:0] ACT_EOE     = 3'd1;
  localparam logic [2:0] ACT_LD_THR  = 3'd2;
  localparam logic [2:0] ACT_LD_SLP  = 3'd3;
  localparam logic [2:0] ACT_LD_ICPT = 3'd4;

  // layers
  localparam logic [1:0] LAYER_FRONT     = 2'd0;
  localparam logic [1:0] LAYER_MID_FRONT = 2'd1;
  localparam logic [1:0] LAYER_MID_BACK  = 2'd2;
  localparam logic [1:0] LAYER_CRYSTAL   = 2'd3;

  // output record kinds
  localparam logic [1:0] KIND_HIT    = 2'd0;
  localparam logic [1:0] KIND_COUNTS = 2'd1;
  localparam logic [1:0] KIND_TOTALS = 2'd2;

  // dead middle front strips
  localparam logic [1:0] BROKEN_DET_A    = 2'd1;
  localparam logic [3:0] BROKEN_DET_A_C0 = 4'd0;
  localparam logic [3:0] BROKEN_DET_A_C1 = 4'd1;
  localparam logic [1:0] BROKEN_DET_B    = 2'd3;
  localparam logic [3:0] BROKEN_DET_B_C0 = 4'd13;
  localparam logic [3:0] BROKEN_DET_B_C1 = 4'd14;

endpackage

// ----- design/zsch_ram.sv -----
// ----------------------------------------------------------------------------
// zsch_ram
// single-port synchronous ram, registered read held when not enabled
// ----------------------------------------------------------------------------
module zsch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/zero_suppress_calibrate_hits_unit.sv -----
// ----------------------------------------------------------------------------
// zero suppress calibrate hits unit
// threshold cut, linear calibration and per-event hit counting of samples
// ----------------------------------------------------------------------------
// usage:
//   the s_axis channel takes one beat per sample, end-of-event or table load;
//   tuser carries the action. the m_axis channel gives hit records and, for
//   an end-of-event beat, one count record per detector then a totals record
//   with tlast set; tuser carries the record kind.
//   tables must be loaded before samples that read them.
// pipeline and rate:
//   a hit goes from its input beat through the stage 1, stage 2 and
//   output registers; samples and loads go at one beat per cycle unless
//   stalled, through threshold read, compare and multiply, then add and
//   saturate. an end-of-event beat yields NUM_DETECTORS+1 output records.
// reset:
//   hit counters and all valid flags clear at once; tables hold garbage
//   until loaded, there is no clearing pass.
// stall:
//   when m_axis_tready_i is low the output beat holds, the two pipeline
//   stages fill and then s_axis_tready_o drops; nothing is lost.
module zero_suppress_calibrate_hits_unit #(
  parameter int NUM_DETECTORS         = 4,
  parameter int STRIPS_PER_LAYER      = 16,
  parameter int CRYSTALS_PER_DETECTOR = 9
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // s_axis
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // layer[1:0] detector[3:2] channel[7:4] value[23:8] hit_time[39:24]
  // table_word[71:40]
  input  logic [zsch_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // action[2:0]
  input  logic [zsch_pkg::IN_USER_W-1:0]   s_axis_tuser_i,
  // m_axis
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // out_layer[1:0] out_detector[3:2] out_channel[7:4] energy[39:8]
  // out_time[55:40] raw_value[71:56] front_count[78:72]
  // mid_front_count[85:79] mid_back_count[92:86] crystal_count[99:93]
  // zero pad[103:100]
  output logic [zsch_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // kind[1:0]
  output logic [zsch_pkg::OUT_USER_W-1:0]  m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);

  import zsch_pkg::*;

  // table geometry
  localparam int ROW_LEN   = (STRIPS_PER_LAYER > CRYSTALS_PER_DETECTOR) ?
                             STRIPS_PER_LAYER : CRYSTALS_PER_DETECTOR;
  localparam int THR_DEPTH = NUM_LAYERS * NUM_DETECTORS * ROW_LEN;
  localparam int CAL_DEPTH = 3 * NUM_DETECTORS * STRIPS_PER_LAYER;
  localparam int CNT_DEPTH = NUM_LAYERS * NUM_DETECTORS;
  localparam int THR_AW    = (THR_DEPTH > 1) ? $clog2(THR_DEPTH) : 1;
  localparam int CAL_AW    = (CAL_DEPTH > 1) ? $clog2(CAL_DEPTH) : 1;
  localparam int CNT_AW    = $clog2(CNT_DEPTH);
  localparam int REC_W     = $clog2(NUM_DETECTORS + 1);

  // ---------------------------------------------------------------------------
  // input decode and table access
  // ---------------------------------------------------------------------------
  logic [2:0]        in_act;
  logic [1:0]        in_layer;
  logic [1:0]        in_det;
  logic [3:0]        in_ch;
  logic [15:0]       in_value;
  logic [15:0]       in_time;
  logic [31:0]       in_word;
  logic              in_ok;
  logic              in_accept;
  logic [THR_AW-1:0] thr_addr;
  logic [CAL_AW-1:0] cal_addr;
  logic              thr_we;
  logic              slp_we;
  logic              icpt_we;
  logic [31:0]       thr_rdata;
  logic [31:0]       slp_rdata;
  logic [31:0]       icpt_rdata;

  assign in_act   = s_axis_tuser_i;
  assign in_layer = s_axis_tdata_i[1:0];
  assign in_det   = s_axis_tdata_i[3:2];
  assign in_ch    = s_axis_tdata_i[7:4];
  assign in_value = s_axis_tdata_i[23:8];
  assign in_time  = s_axis_tdata_i[39:24];
  assign in_word  = s_axis_tdata_i[71:40];

  // detector and channel inside the configured geometry
  assign in_ok = (32'(in_det) < 32'(NUM_DETECTORS)) &&
                 ((in_layer == LAYER_CRYSTAL) ?
                  (32'(in_ch) < 32'(CRYSTALS_PER_DETECTOR)) :
                  (32'(in_ch) < 32'(STRIPS_PER_LAYER)));

  assign thr_addr = THR_AW'((32'(in_layer) * 32'(NUM_DETECTORS) + 32'(in_det))
                            * 32'(ROW_LEN) + 32'(in_ch));
  // crystals have no calibration row, park the address at zero
  assign cal_addr = (in_layer == LAYER_CRYSTAL) ? '0 :
                    CAL_AW'((32'(in_layer) * 32'(NUM_DETECTORS) + 32'(in_det))
                            * 32'(STRIPS_PER_LAYER) + 32'(in_ch));

  assign in_accept = s_axis_tvalid_i & s_axis_tready_o;
  assign thr_we    = in_accept & (in_act == ACT_LD_THR) & in_ok;
  assign slp_we    = in_accept & (in_act == ACT_LD_SLP) & in_ok &
                     (in_layer != LAYER_CRYSTAL);
  assign icpt_we   = in_accept & (in_act == ACT_LD_ICPT) & in_ok &
                     (in_layer != LAYER_CRYSTAL);

  // reads only on an accepted beat so the data stays lined up with stage 1
  zsch_ram #(.WIDTH(32), .DEPTH(THR_DEPTH)) u_thr_ram (
    .clk_i  (clk_i),
    .we_i   (thr_we),
    .re_i   (in_accept),
    .addr_i (thr_addr),
    .wdata_i(in_word),
    .rdata_o(thr_rdata)
  );

  zsch_ram #(.WIDTH(32), .DEPTH(CAL_DEPTH)) u_slp_ram (
    .clk_i  (clk_i),
    .we_i   (slp_we),
    .re_i   (in_accept),
    .addr_i (cal_addr),
    .wdata_i(in_word),
    .rdata_o(slp_rdata)
  );

  zsch_ram #(.WIDTH(32), .DEPTH(CAL_DEPTH)) u_icpt_ram (
    .clk_i  (clk_i),
    .we_i   (icpt_we),
    .re_i   (in_accept),
    .addr_i (cal_addr),
    .wdata_i(in_word),
    .rdata_o(icpt_rdata)
  );

  // ---------------------------------------------------------------------------
  // stage 1: threshold compare, broken-channel drop, multiply, counters
  // ---------------------------------------------------------------------------
  logic              s1_valid_q;
  logic [2:0]        s1_act_q;
  logic [1:0]        s1_layer_q;
  logic [1:0]        s1_det_q;
  logic [3:0]        s1_ch_q;
  logic [15:0]       s1_value_q;
  logic [15:0]       s1_time_q;
  logic              s1_ok_q;
  logic              s1_pass;
  logic              s1_broken;
  logic              s1_hit;
  logic              s1_eoe;
  logic              s1_go;
  logic signed [48:0] s1_prod;
  logic [CNT_AW-1:0] s1_cnt_idx;

  logic              s2_ready;

  assign s_axis_tready_o = ~s1_valid_q | s2_ready;
  assign s1_go           = s1_valid_q & s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_act_q   <= in_act;
      s1_layer_q <= in_layer;
      s1_det_q   <= in_det;
      s1_ch_q    <= in_ch;
      s1_value_q <= in_value;
      s1_time_q  <= in_time;
      s1_ok_q    <= in_ok;
    end
  end

  // strictly greater, raw value unsigned against signed threshold
  assign s1_pass = $signed({17'd0, s1_value_q}) > $signed({thr_rdata[31], thr_rdata});

  assign s1_broken = (s1_layer_q == LAYER_MID_FRONT) &&
                     (((s1_det_q == BROKEN_DET_A) &&
                       ((s1_ch_q == BROKEN_DET_A_C0) || (s1_ch_q == BROKEN_DET_A_C1))) ||
                      ((s1_det_q == BROKEN_DET_B) &&
                       ((s1_ch_q == BROKEN_DET_B_C0) || (s1_ch_q == BROKEN_DET_B_C1))));

  assign s1_hit = (s1_act_q == ACT_SAMPLE) & s1_ok_q & s1_pass & ~s1_broken;
  assign s1_eoe = (s1_act_q == ACT_EOE);

  assign s1_prod    = $signed(slp_rdata) * $signed({1'b0, s1_value_q});
  assign s1_cnt_idx = CNT_AW'(32'(s1_det_q) * 32'(NUM_LAYERS) + 32'(s1_layer_q));

  // hit counters, one per detector and layer
  logic [CNT_W-1:0] cnt_q [CNT_DEPTH];
  logic [CNT_W-1:0] cnt_d [CNT_DEPTH];
  logic             cnt_zero;

  always_comb begin
    cnt_d = cnt_q;
    if (s1_go && s1_eoe) begin
      for (int i = 0; i < CNT_DEPTH; i++) begin
        cnt_d[i] = '0;
      end
    end else if (s1_go && s1_hit && (cnt_q[s1_cnt_idx] != CNT_MAX)) begin
      cnt_d[s1_cnt_idx] = cnt_q[s1_cnt_idx] + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CNT_DEPTH; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    cnt_zero = 1'b1;
    for (int i = 0; i < CNT_DEPTH; i++) begin
      cnt_zero = cnt_zero & (cnt_q[i] == '0);
    end
  end

  // event totals from the counters about to be cleared
  logic [7:0]       tot_sum [NUM_LAYERS];
  logic [TOT_W-1:0] tot_sat [NUM_LAYERS];

  always_comb begin
    for (int l = 0; l < NUM_LAYERS; l++) begin
      tot_sum[l] = '0;
      for (int d = 0; d < NUM_DETECTORS; d++) begin
        tot_sum[l] = tot_sum[l] + 8'(cnt_q[CNT_AW'(d * NUM_LAYERS + l)]);
      end
      tot_sat[l] = (tot_sum[l] > 8'(TOT_MAX)) ? TOT_MAX : tot_sum[l][TOT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: add intercept, saturate, hold end-of-event snapshot
  // ---------------------------------------------------------------------------
  logic               s2_valid_q;
  logic               s2_eoe_q;
  logic [1:0]         s2_layer_q;
  logic [1:0]         s2_det_q;
  logic [3:0]         s2_ch_q;
  logic [15:0]        s2_value_q;
  logic [15:0]        s2_time_q;
  logic signed [48:0] s2_prod_q;
  logic signed [31:0] s2_icpt_q;
  logic [CNT_W-1:0]   snap_q [CNT_DEPTH];
  logic [TOT_W-1:0]   tot_q [NUM_LAYERS];
  logic [REC_W-1:0]   rec_q;
  logic               rec_last;
  logic               out_free;
  logic               out_load;
  logic               s2_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_go & (s1_hit | s1_eoe);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_eoe_q   <= s1_eoe;
      s2_layer_q <= s1_layer_q;
      s2_det_q   <= s1_det_q;
      s2_ch_q    <= s1_ch_q;
      s2_value_q <= s1_value_q;
      s2_time_q  <= s1_time_q;
      s2_prod_q  <= s1_prod;
      s2_icpt_q  <= $signed(icpt_rdata);
    end
    if (s1_go && s1_eoe) begin
      snap_q <= cnt_q;
      tot_q  <= tot_sat;
    end
  end

  // record counter walks detectors, then the totals record
  assign rec_last = (32'(rec_q) == 32'(NUM_DETECTORS));
  assign out_free = ~m_axis_tvalid_o | m_axis_tready_i;
  assign out_load = s2_valid_q & out_free;
  assign s2_done  = out_load & (~s2_eoe_q | rec_last);
  assign s2_ready = ~s2_valid_q | s2_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (s2_done) begin
      rec_q <= '0;
    end else if (out_load && s2_eoe_q) begin
      rec_q <= rec_q + REC_W'(1);
    end
  end

  // q16.16 energy, 49-bit product plus intercept, clamped to 32 bits
  logic signed [49:0] cal_sum;
  logic [31:0]        cal_energy;

  assign cal_sum = 50'(s2_prod_q) + 50'(s2_icpt_q);

  always_comb begin
    if ((&cal_sum[49:31]) || !(|cal_sum[49:31])) begin
      cal_energy = cal_sum[31:0];
    end else if (cal_sum[49]) begin
      cal_energy = 32'h8000_0000;
    end else begin
      cal_energy = 32'h7fff_ffff;
    end
  end

  // record assembly
  logic [1:0]       rec_kind;
  logic [1:0]       rec_layer;
  logic [1:0]       rec_det;
  logic [3:0]       rec_ch;
  logic [31:0]      rec_energy;
  logic [15:0]      rec_time;
  logic [15:0]      rec_raw;
  logic [TOT_W-1:0] rec_cnt [NUM_LAYERS];
  logic             rec_tlast;

  always_comb begin
    rec_kind   = KIND_HIT;
    rec_layer  = '0;
    rec_det    = '0;
    rec_ch     = '0;
    rec_energy = '0;
    rec_time   = '0;
    rec_raw    = '0;
    rec_tlast  = 1'b0;
    for (int l = 0; l < NUM_LAYERS; l++) begin
      rec_cnt[l] = '0;
    end
    if (!s2_eoe_q) begin
      rec_layer  = s2_layer_q;
      rec_det    = s2_det_q;
      rec_ch     = s2_ch_q;
      rec_energy = (s2_layer_q == LAYER_CRYSTAL) ? '0 : cal_energy;
      rec_time   = (s2_layer_q == LAYER_MID_FRONT) ? s2_time_q : '0;
      rec_raw    = s2_value_q;
    end else if (rec_last) begin
      rec_kind  = KIND_TOTALS;
      rec_tlast = 1'b1;
      rec_cnt   = tot_q;
    end else begin
      rec_kind = KIND_COUNTS;
      rec_det  = 2'(rec_q);
      for (int d = 0; d < NUM_DETECTORS; d++) begin
        if (32'(rec_q) == 32'(d)) begin
          for (int l = 0; l < NUM_LAYERS; l++) begin
            rec_cnt[l] = TOT_W'(snap_q[CNT_AW'(d * NUM_LAYERS + l)]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [1:0]            out_kind_q;
  logic                  out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {4'd0, rec_cnt[3], rec_cnt[2], rec_cnt[1], rec_cnt[0],
                     rec_raw, rec_time, rec_energy, rec_ch, rec_det, rec_layer};
      out_kind_q <= rec_kind;
      out_last_q <= rec_tlast;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`include "zero_suppress_calibrate_hits_unit_assert.svh"

  // record counter only moves during an end-of-event run
  `ZSCH_ASSERT_IMPLIES(a_rec_idle, s2_valid_q && !s2_eoe_q, rec_q == '0, "record counter busy on a hit")
  // tlast marks exactly the totals record
  `ZSCH_ASSERT_IMPLIES(a_last_totals, m_axis_tvalid_o, m_axis_tlast_o == (m_axis_tuser_o == KIND_TOTALS), "tlast and record kind disagree")
  // end of event leaves every counter cleared
  `ZSCH_ASSERT_NEXT(a_eoe_clears, s1_go && s1_eoe, cnt_zero, "hit counters not cleared at end of event")

endmodule

// ----- test/tb_zero_suppress_calibrate_hits_unit.sv -----
// ----------------------------------------------------------------------------
// tb_zero_suppress_calibrate_hits_unit
// self-checking bench: directed table loads and samples, then random events
// under four idle mixes, every output beat compared against a predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_zero_suppress_calibrate_hits_unit;
  import zsch_pkg::*;

  localparam int NUM_DET   = 4;
  localparam int STRIPS    = 16;
  localparam int CRYSTALS  = 9;
  localparam int ROW_LEN   = (STRIPS > CRYSTALS) ? STRIPS : CRYSTALS;
  localparam int THR_DEPTH = NUM_LAYERS * NUM_DET * ROW_LEN;
  localparam int CAL_DEPTH = 3 * NUM_DET * STRIPS;
  localparam int CNT_DEPTH = NUM_DET * NUM_LAYERS;

  localparam longint E_MAX = 2147483647;
  localparam longint E_MIN = -E_MAX - 1;

  // reserved action codes, the block must swallow them
  localparam logic [2:0] ACT_RSVD_LO = 3'd5;
  localparam logic [2:0] ACT_RSVD_HI = 3'd7;

  localparam int RESET_CYCLES    = 5;
  localparam int ITEMS_PER_PHASE = 35;
  localparam int TAIL_CYCLES     = 10;
  localparam int CYCLE_LIMIT     = 200000;

  // input beat, last field in the low bits, matches s_axis_tdata_i
  typedef struct packed {
    logic [31:0] table_word;
    logic [15:0] hit_time;
    logic [15:0] value;
    logic [3:0]  channel;
    logic [1:0]  detector;
    logic [1:0]  layer;
  } samp_beat_t;

  // output beat payload, matches m_axis_tdata_o
  typedef struct packed {
    logic [3:0]                       pad;
    logic [NUM_LAYERS-1:0][TOT_W-1:0] cnt;  // [0] front .. [3] crystal
    logic [15:0]                      raw_value;
    logic [15:0]                      out_time;
    logic [31:0]                      energy;
    logic [3:0]                       channel;
    logic [1:0]                       detector;
    logic [1:0]                       layer;
  } rec_data_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       last;
    rec_data_t  d;
  } hit_rec_t;

  // --------------------------------------------------------------------------
  // predictor and result store
  // --------------------------------------------------------------------------
  class calib_scoreboard;
    int             thr_tbl    [THR_DEPTH];
    int             gain_tbl   [CAL_DEPTH];
    int             offset_tbl [CAL_DEPTH];
    bit [CNT_W-1:0] hit_cnt    [CNT_DEPTH];
    hit_rec_t       pending_records [$];
    string          cnt_name [NUM_LAYERS] =
      '{"front_count", "mid_front_count", "mid_back_count", "crystal_count"};
    int errors;
    int hits_seen;
    int counts_seen;
    int totals_seen;

    // works out the records caused by one accepted input beat
    function void predict_records(logic [2:0] act, samp_beat_t b);
      int unsigned tidx, cidx, k;
      int          tot [NUM_LAYERS];
      int          d, l;
      longint      e;
      bit          in_range, dead;
      hit_rec_t    r;
      tidx = (b.layer * NUM_DET + b.detector) * ROW_LEN + b.channel;
      cidx = (b.layer * NUM_DET + b.detector) * STRIPS + b.channel;
      in_range = (b.detector < NUM_DET) &&
                 ((b.layer == LAYER_CRYSTAL) ? (b.channel < CRYSTALS) : (b.channel < STRIPS));
      dead = (b.layer == LAYER_MID_FRONT) &&
             ((b.detector == BROKEN_DET_A &&
               (b.channel == BROKEN_DET_A_C0 || b.channel == BROKEN_DET_A_C1)) ||
              (b.detector == BROKEN_DET_B &&
               (b.channel == BROKEN_DET_B_C0 || b.channel == BROKEN_DET_B_C1)));
      if (act == ACT_EOE) begin
        for (l = 0; l < NUM_LAYERS; l++) tot[l] = 0;
        for (d = 0; d < NUM_DET; d++) begin
          r = '0;
          r.kind = KIND_COUNTS;
          r.d.detector = d[1:0];
          for (l = 0; l < NUM_LAYERS; l++) begin
            r.d.cnt[l] = TOT_W'(hit_cnt[d * NUM_LAYERS + l]);
            tot[l] += hit_cnt[d * NUM_LAYERS + l];
          end
          pending_records.insert(pending_records.size(), r);
        end
        r = '0;
        r.kind = KIND_TOTALS;
        r.last = 1'b1;
        for (l = 0; l < NUM_LAYERS; l++)
          r.d.cnt[l] = (tot[l] > TOT_MAX) ? TOT_MAX : tot[l][TOT_W-1:0];
        pending_records.insert(pending_records.size(), r);
        for (k = 0; k < CNT_DEPTH; k++) hit_cnt[k] = '0;
      end else if (act <= ACT_LD_ICPT && in_range) begin
        case (act)
          ACT_LD_THR:  thr_tbl[tidx] = b.table_word;
          ACT_LD_SLP:  if (b.layer != LAYER_CRYSTAL) gain_tbl[cidx] = b.table_word;
          ACT_LD_ICPT: if (b.layer != LAYER_CRYSTAL) offset_tbl[cidx] = b.table_word;
          default: begin
            // strictly above a signed threshold, dead strips drop before counting
            if (longint'(b.value) > longint'(thr_tbl[tidx]) && !dead) begin
              k = b.detector * NUM_LAYERS + b.layer;
              if (hit_cnt[k] < CNT_MAX) hit_cnt[k]++;
              r = '0;
              r.kind = KIND_HIT;
              r.d.layer = b.layer;
              r.d.detector = b.detector;
              r.d.channel = b.channel;
              r.d.raw_value = b.value;
              if (b.layer == LAYER_MID_FRONT) r.d.out_time = b.hit_time;
              if (b.layer != LAYER_CRYSTAL) begin
                e = longint'(gain_tbl[cidx]) * longint'(b.value) + longint'(offset_tbl[cidx]);
                if (e > E_MAX) e = E_MAX;
                if (e < E_MIN) e = E_MIN;
                r.d.energy = e[31:0];
              end
              pending_records.insert(pending_records.size(), r);
            end
          end
        endcase
      end
    endfunction

    function void compare_field(string fld, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", fld, want, got);
        errors++;
      end
    endfunction

    function void check_record(hit_rec_t got);
      hit_rec_t want;
      int       l;
      case (got.kind)
        KIND_HIT:    hits_seen++;
        KIND_COUNTS: counts_seen++;
        default:     totals_seen++;
      endcase
      if (pending_records.size() == 0) begin
        $error("output beat of kind %0d with nothing expected", got.kind);
        errors++;
        return;
      end
      want = pending_records.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("last", want.last, got.last);
      compare_field("out_layer", want.d.layer, got.d.layer);
      compare_field("out_detector", want.d.detector, got.d.detector);
      compare_field("out_channel", want.d.channel, got.d.channel);
      compare_field("energy", $signed(want.d.energy), $signed(got.d.energy));
      compare_field("out_time", want.d.out_time, got.d.out_time);
      compare_field("raw_value", want.d.raw_value, got.d.raw_value);
      for (l = 0; l < NUM_LAYERS; l++)
        compare_field(cnt_name[l], want.d.cnt[l], got.d.cnt[l]);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // dut and its drive
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;  // layer, detector, channel, value,
                                                // hit_time, table_word
  logic [IN_USER_W-1:0]  s_axis_tuser_i  = '0;  // action
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;        // out_layer, out_detector, out_channel,
                                                // energy, out_time, raw_value, counts
  logic [OUT_USER_W-1:0] m_axis_tuser_o;        // kind
  logic                  m_axis_tlast_o;

  zero_suppress_calibrate_hits_unit #(
    .NUM_DETECTORS         (NUM_DET),
    .STRIPS_PER_LAYER      (STRIPS),
    .CRYSTALS_PER_DETECTOR (CRYSTALS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  calib_scoreboard hit_sb = new();

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int beats_in       = 0;
  int items_done     = 0;
  int cycle_cnt      = 0;

  // which table entries hold loaded data; samples only go to fully loaded ones
  bit         thr_set    [THR_DEPTH];
  bit         gain_set   [CAL_DEPTH];
  bit         offset_set [CAL_DEPTH];
  bit         on_list    [THR_DEPTH];
  logic [7:0] sample_keys [$];  // {layer, detector, channel}

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d records still due", cycle_cnt,
             hit_sb.pending_records.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random back-pressure, checks every accepted output beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($isunknown(m_axis_tvalid_o)) begin
        $error("m_axis_tvalid_o unknown");
        hit_sb.errors++;
      end else if (m_axis_tvalid_o && m_axis_tready_i) begin
        hit_sb.check_record({m_axis_tuser_o, m_axis_tlast_o, m_axis_tdata_o});
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  function automatic samp_beat_t rand_beat();
    logic [95:0] w;
    w = {$urandom, $urandom, $urandom};
    return w[IN_DATA_W-1:0];
  endfunction

  // one beat, with an optional random gap in front; tvalid stays high after
  task automatic send_beat(input logic [2:0] act, input samp_beat_t b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= act;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    hit_sb.predict_records(act, b);
    beats_in++;
    if (act <= ACT_LD_ICPT) items_done++;
  endtask

  // hold the sender off until every expected record has come out
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (hit_sb.pending_records.size() != 0);
  endtask

  function automatic void track_load(logic [2:0] act, samp_beat_t b);
    int unsigned t, c;
    bit          strip;
    strip = (b.layer != LAYER_CRYSTAL);
    t = (b.layer * NUM_DET + b.detector) * ROW_LEN + b.channel;
    c = (b.layer * NUM_DET + b.detector) * STRIPS + b.channel;
    if (b.detector < NUM_DET && (strip || b.channel < CRYSTALS)) begin
      if (act == ACT_LD_THR) thr_set[t] = 1'b1;
      else if (strip && act == ACT_LD_SLP) gain_set[c] = 1'b1;
      else if (strip && act == ACT_LD_ICPT) offset_set[c] = 1'b1;
      if (!on_list[t] && thr_set[t] && (!strip || (gain_set[c] && offset_set[c]))) begin
        on_list[t] = 1'b1;
        sample_keys.insert(sample_keys.size(), {b.layer, b.detector, b.channel});
      end
    end
  endfunction

  task automatic send_load(input logic [2:0] act, input logic [1:0] lyr,
                           input logic [1:0] det, input logic [3:0] ch,
                           input logic [31:0] word);
    samp_beat_t b;
    b = rand_beat();
    b.layer = lyr;
    b.detector = det;
    b.channel = ch;
    b.table_word = word;
    track_load(act, b);
    send_beat(act, b);
  endtask

  task automatic send_sample(input logic [1:0] lyr, input logic [1:0] det,
                             input logic [3:0] ch, input logic [15:0] val,
                             input logic [15:0] tm);
    samp_beat_t b;
    b = rand_beat();
    b.layer = lyr;
    b.detector = det;
    b.channel = ch;
    b.value = val;
    b.hit_time = tm;
    send_beat(ACT_SAMPLE, b);
  endtask

  task automatic send_eoe();
    send_beat(ACT_EOE, rand_beat());
  endtask

  task automatic rand_load();
    logic [2:0]  act;
    logic [1:0]  lyr;
    logic [3:0]  ch;
    logic [31:0] word;
    act = 3'($urandom_range(ACT_LD_THR, ACT_LD_ICPT));
    lyr = (act == ACT_LD_THR) ? 2'($urandom_range(LAYER_FRONT, LAYER_CRYSTAL))
                              : 2'($urandom_range(LAYER_FRONT, LAYER_MID_BACK));
    ch = (lyr == LAYER_CRYSTAL) ? 4'($urandom_range(0, CRYSTALS - 1))
                                : 4'($urandom_range(0, STRIPS - 1));
    case (act)
      ACT_LD_THR: begin
        case ($urandom_range(0, 9))
          0:       word = $urandom;            // mostly always-pass or never-pass
          1:       word = 32'h8000_0000;
          2:       word = 32'h7FFF_FFFF;
          default: word = $urandom_range(0, 40000);
        endcase
      end
      ACT_LD_SLP: begin
        // gains around +-4.0, now and then a wild one for saturation
        word = ($urandom_range(0, 4) == 0) ? $urandom
                                           : $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      end
      default: begin
        word = ($urandom_range(0, 4) == 0) ? $urandom
                                           : $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      end
    endcase
    send_load(act, lyr, 2'($urandom_range(0, NUM_DET - 1)), ch, word);
  endtask

  // a handful of samples on loaded channels, loads mixed in, closed by end of event
  task automatic rand_event();
    int         n;
    logic [7:0] key;
    logic [15:0] val;
    n = $urandom_range(0, 8);
    repeat (n) begin
      if (sample_keys.size() != 0 && $urandom_range(0, 9) != 0) begin
        key = sample_keys[$urandom_range(0, sample_keys.size() - 1)];
        case ($urandom_range(0, 9))
          0:       val = 16'h0000;
          1:       val = 16'hFFFF;
          default: val = 16'($urandom);
        endcase
        send_sample(key[7:6], key[5:4], key[3:0], val, 16'($urandom));
      end else begin
        rand_load();
      end
    end
    send_eoe();
  endtask

  // beats the block has to swallow without a trace
  task automatic send_noise();
    samp_beat_t b;
    b = rand_beat();
    case ($urandom_range(0, 3))
      0: send_beat(3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI)), b);
      1: send_sample(LAYER_CRYSTAL, 2'($urandom_range(0, NUM_DET - 1)),
                     4'($urandom_range(CRYSTALS, 15)), 16'($urandom), 16'($urandom));
      2: send_load(3'($urandom_range(ACT_LD_SLP, ACT_LD_ICPT)), LAYER_CRYSTAL,
                   2'($urandom_range(0, NUM_DET - 1)),
                   4'($urandom_range(0, CRYSTALS - 1)), $urandom);
      default: send_load(ACT_LD_THR, LAYER_CRYSTAL, 2'($urandom_range(0, NUM_DET - 1)),
                         4'($urandom_range(CRYSTALS, 15)), $urandom);
    endcase
  endtask

  // one channel hammered past the counter ceiling inside a single event
  task automatic counter_burst();
    send_load(ACT_LD_THR, LAYER_MID_BACK, 2'd2, 4'd7, 32'hFFFF_FFFF);
    send_load(ACT_LD_SLP, LAYER_MID_BACK, 2'd2, 4'd7, $urandom);
    send_load(ACT_LD_ICPT, LAYER_MID_BACK, 2'd2, 4'd7, $urandom);
    repeat (int'(CNT_MAX) + 3)
      send_sample(LAYER_MID_BACK, 2'd2, 4'd7, 16'($urandom), 16'($urandom));
    send_eoe();
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int ph, pick, phase_end;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unit gain, equal-to-threshold cut
    send_load(ACT_LD_THR, LAYER_FRONT, 2'd0, 4'd0, 32'd100);
    send_load(ACT_LD_SLP, LAYER_FRONT, 2'd0, 4'd0, 32'h0001_0000);
    send_load(ACT_LD_ICPT, LAYER_FRONT, 2'd0, 4'd0, 32'h0000_0000);
    send_sample(LAYER_FRONT, 2'd0, 4'd0, 16'd101, 16'hFFFF);
    send_sample(LAYER_FRONT, 2'd0, 4'd0, 16'd100, 16'hFFFF);
    // middle front, negative threshold, saturation high, time carried
    send_load(ACT_LD_THR, LAYER_MID_FRONT, 2'd2, 4'd15, 32'hFFFF_FFFF);
    send_load(ACT_LD_SLP, LAYER_MID_FRONT, 2'd2, 4'd15, 32'h7FFF_FFFF);
    send_load(ACT_LD_ICPT, LAYER_MID_FRONT, 2'd2, 4'd15, 32'h7FFF_FFFF);
    send_sample(LAYER_MID_FRONT, 2'd2, 4'd15, 16'hFFFF, 16'hFFFF);
    // middle back, saturation low, zero value at zero threshold
    send_load(ACT_LD_THR, LAYER_MID_BACK, 2'd3, 4'd5, 32'h0000_0000);
    send_load(ACT_LD_SLP, LAYER_MID_BACK, 2'd3, 4'd5, 32'h8000_0000);
    send_load(ACT_LD_ICPT, LAYER_MID_BACK, 2'd3, 4'd5, 32'h8000_0000);
    send_sample(LAYER_MID_BACK, 2'd3, 4'd5, 16'hFFFF, 16'hFFFF);
    send_sample(LAYER_MID_BACK, 2'd3, 4'd5, 16'h0000, 16'hFFFF);
    // crystal: raw value only, gain load ignored, channel past the last crystal
    send_load(ACT_LD_THR, LAYER_CRYSTAL, 2'd3, 4'd8, 32'd65534);
    send_load(ACT_LD_SLP, LAYER_CRYSTAL, 2'd3, 4'd8, 32'h0001_0000);
    send_sample(LAYER_CRYSTAL, 2'd3, 4'd8, 16'hFFFF, 16'hFFFF);
    send_sample(LAYER_CRYSTAL, 2'd3, 4'd15, 16'hFFFF, 16'hFFFF);
    // dead strip always dropped
    send_load(ACT_LD_THR, LAYER_MID_FRONT, BROKEN_DET_B, BROKEN_DET_B_C1, 32'hFFFF_FFFF);
    send_load(ACT_LD_SLP, LAYER_MID_FRONT, BROKEN_DET_B, BROKEN_DET_B_C1, 32'h0001_0000);
    send_load(ACT_LD_ICPT, LAYER_MID_FRONT, BROKEN_DET_B, BROKEN_DET_B_C1, 32'h0000_0000);
    send_sample(LAYER_MID_FRONT, BROKEN_DET_B, BROKEN_DET_B_C1, 16'd500, 16'd7);
    // reserved actions, then close the event
    send_beat(ACT_RSVD_LO, rand_beat());
    send_beat(ACT_RSVD_HI, rand_beat());
    send_eoe();

    // random part: free flow, sender gaps, receiver stalls, both
    for (ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 75; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 75; end
        default: begin src_idle_pct = 25; sink_stall_pct = 25; end
      endcase
      if (ph == 1) counter_burst();
      phase_end = items_done + ITEMS_PER_PHASE;
      while (items_done < phase_end) begin
        pick = $urandom_range(0, 99);
        // load heavily until enough channels are usable
        if ((sample_keys.size() < 12 && pick < 40) || pick < 15)
          repeat ($urandom_range(1, 4)) rand_load();
        else if (pick < 88)
          rand_event();
        else
          send_noise();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d input beats (%0d loaded channels), %0d hits, %0d count records, %0d totals",
             beats_in, sample_keys.size(), hit_sb.hits_seen, hit_sb.counts_seen,
             hit_sb.totals_seen);
    $display("idle mixes: free flow, sender 75%%, receiver 75%%, both 25%%; counter ceiling hit");
    if (hit_sb.errors == 0 && hit_sb.pending_records.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- zero_suppress_calibrate_hits_unit.f -----
+incdir+design
design/zsch_pkg.sv
design/zsch_ram.sv
design/zero_suppress_calibrate_hits_unit.sv
test/tb_zero_suppress_calibrate_hits_unit.sv
